// File: sv/tle_pkg.sv
// shared types, character codes and echo tables for the terminal line editor
`timescale 1ns / 1ps

package tle_pkg;

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // request selector on the input stream
    localparam logic REQ_EDIT = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // command classes passed from front to back
    typedef enum logic [2:0] {
        OP_READ,
        OP_LINE_END,
        OP_ERASE,
        OP_INTR,
        OP_CHAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    // result kinds on the output stream
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    // echo character for a given step of a command
    function automatic logic [7:0] echo_byte(input t_op op, input logic [1:0] step,
                                             input logic [7:0] ch);
        logic [7:0] b;
        b = ch;
        case (op)
            OP_LINE_END: b = (step == 2'd0) ? CH_CR : CH_LF;
            OP_ERASE:    b = (step == 2'd1) ? CH_SP : CH_BS;
            OP_INTR: begin
                case (step)
                    2'd0:    b = CH_CARET;
                    2'd1:    b = CH_C;
                    2'd2:    b = CH_CR;
                    default: b = CH_LF;
                endcase
            end
            default:     b = ch;
        endcase
        return b;
    endfunction

    // index of the final echo step of a command
    function automatic logic [1:0] echo_last(input t_op op);
        logic [1:0] s;
        case (op)
            OP_LINE_END: s = 2'd1;
            OP_ERASE:    s = 2'd2;
            OP_INTR:     s = 2'd3;
            default:     s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

// File: sv/tle_front.sv
// input side: accepts request beats and classifies them into commands
`timescale 1ns / 1ps

module tle_front (
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tuser,
    output logic         o_q_valid,
    input  logic         i_q_ready,
    output tle_pkg::t_cmd o_q_cmd
);
    import tle_pkg::*;

    // handshake passes straight into the queue
    assign o_s_tready = i_q_ready;
    assign o_q_valid  = i_s_tvalid;

    // classify the received character
    always_comb begin
        o_q_cmd.ch = i_s_tdata;
        if (i_s_tuser == REQ_READ) begin
            o_q_cmd.op = OP_READ;
        end else begin
            case (i_s_tdata) inside
                CH_CR, CH_LF:   o_q_cmd.op = OP_LINE_END;
                CH_BS, CH_DEL:  o_q_cmd.op = OP_ERASE;
                CH_ETX:         o_q_cmd.op = OP_INTR;
                default:        o_q_cmd.op = OP_CHAR;
            endcase
        end
    end

endmodule

// File: sv/tle_cmd_queue.sv
// two-entry command queue between the front and back parts
`timescale 1ns / 1ps

module tle_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  tle_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output tle_pkg::t_cmd o_pop_cmd
);
    import tle_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

// File: sv/tle_back.sv
// back part: line store, committed-line ring, echo sequencer and result register
`timescale 1ns / 1ps

module tle_back #(
    parameter int LINE_SIZE = 256,
    parameter int RING_SIZE = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  tle_pkg::t_cmd  i_cmd,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_data,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output logic [7:0]     o_m_data,
    output tle_pkg::t_kind o_m_kind,
    output logic           o_m_last
);
    import tle_pkg::*;

    localparam int LW = $clog2(LINE_SIZE);
    localparam int RW = $clog2(RING_SIZE);
    localparam logic [LW:0]   LINE_LIMIT = (LW + 1)'(LINE_SIZE);
    localparam logic [RW-1:0] RING_LAST  = RW'(RING_SIZE - 1);
    localparam logic [RW:0]   RING_FULL  = (RW + 1)'(RING_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ECHO,
        S_RDATA,
        S_EMPTY
    } t_state;

    t_state        r_state,    n_state;
    t_op           r_op,       n_op;
    logic [7:0]    r_ch,       n_ch;
    logic [1:0]    r_step,     n_step;
    logic [LW-1:0] r_len,      n_len;
    logic [LW-1:0] r_walk_i,   n_walk_i;
    logic [LW-1:0] r_walk_len, n_walk_len;
    logic          r_lrd_v,    n_lrd_v;
    logic [RW-1:0] r_wr_idx,   n_wr_idx;
    logic [RW-1:0] r_rd_idx,   n_rd_idx;
    logic [RW:0]   r_fill,     n_fill;
    logic          r_echo,     n_echo;
    logic          r_m_valid,  n_m_valid;
    logic [7:0]    r_m_data,   n_m_data;
    t_kind         r_m_kind,   n_m_kind;
    logic          r_m_last,   n_m_last;

    logic [7:0] line_mem [LINE_SIZE];
    logic [7:0] ring_mem [RING_SIZE];
    logic [7:0] r_line_q;
    logic [7:0] r_ring_q;

    logic       w_line_we;
    logic       w_line_re;
    logic       w_ring_re;
    logic       w_push;
    logic [7:0] w_push_byte;
    logic       w_pop;
    logic       w_out_free;

    function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] v);
        return (v == RING_LAST) ? '0 : v + RW'(1);
    endfunction

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_out_free  = !r_m_valid || i_m_ready;
    assign o_m_valid   = r_m_valid;
    assign o_m_data    = r_m_data;
    assign o_m_kind    = r_m_kind;
    assign o_m_last    = r_m_last;

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_ch       = r_ch;
        n_step     = r_step;
        n_len      = r_len;
        n_walk_i   = r_walk_i;
        n_walk_len = r_walk_len;
        n_lrd_v    = 1'b0;
        n_echo     = i_cfg_valid ? i_cfg_data : r_echo;
        n_m_valid  = r_m_valid && !i_m_ready;
        n_m_data   = r_m_data;
        n_m_kind   = r_m_kind;
        n_m_last   = r_m_last;
        w_line_we  = 1'b0;
        w_line_re  = 1'b0;
        w_ring_re  = 1'b0;
        w_push     = 1'b0;
        w_push_byte = CH_LF;
        w_pop      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op   = i_cmd.op;
                    n_ch   = i_cmd.ch;
                    n_step = 2'd0;
                    case (i_cmd.op)
                        OP_READ: begin
                            if (r_fill == '0) begin
                                n_state = S_EMPTY;
                            end else begin
                                w_ring_re = 1'b1;
                                w_pop     = 1'b1;
                                n_state   = S_RDATA;
                            end
                        end
                        OP_LINE_END: begin
                            n_walk_len = r_len;
                            n_walk_i   = '0;
                            n_len      = '0;
                            n_state    = S_WALK;
                        end
                        OP_ERASE: begin
                            if (r_len != '0) begin
                                n_len = r_len - LW'(1);
                                if (r_echo) begin
                                    n_state = S_ECHO;
                                end
                            end
                        end
                        OP_INTR: begin
                            n_len       = '0;
                            w_push      = 1'b1;
                            w_push_byte = CH_ETX;
                            if (r_echo) begin
                                n_state = S_ECHO;
                            end
                        end
                        default: begin
                            // append unless the line is at its limit
                            if ({1'b0, r_len} + (LW + 1)'(1) < LINE_LIMIT) begin
                                w_line_we = 1'b1;
                                n_len     = r_len + LW'(1);
                                if (r_echo) begin
                                    n_state = S_ECHO;
                                end
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                // read stage runs ahead of the push stage, which takes the byte registered in r_line_q
                w_line_re = (r_walk_i != r_walk_len);
                n_lrd_v   = w_line_re;
                if (w_line_re) begin
                    n_walk_i = r_walk_i + LW'(1);
                end
                if (r_lrd_v) begin
                    w_push      = 1'b1;
                    w_push_byte = r_line_q;
                end else if (!w_line_re) begin
                    w_push      = 1'b1;
                    w_push_byte = CH_LF;
                    n_state     = r_echo ? S_ECHO : S_IDLE;
                end
            end
            S_ECHO: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_ECHO;
                    n_m_data  = echo_byte(r_op, r_step, r_ch);
                    n_m_last  = (r_step == echo_last(r_op));
                    if (r_step == echo_last(r_op)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            S_RDATA: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_DATA;
                    n_m_data  = r_ring_q;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_EMPTY;
                    n_m_data  = '0;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ring indexes and fill, a push on a full ring drops the oldest byte
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_idx = ring_inc(r_wr_idx);
            if (r_fill == RING_FULL) begin
                n_rd_idx = ring_inc(r_rd_idx);
            end else begin
                n_fill = r_fill + (RW + 1)'(1);
            end
        end else if (w_pop) begin
            n_rd_idx = ring_inc(r_rd_idx);
            n_fill   = r_fill - (RW + 1)'(1);
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_lrd_v   <= 1'b0;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_fill    <= '0;
            r_echo    <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_lrd_v   <= n_lrd_v;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_fill    <= n_fill;
            r_echo    <= n_echo;
            r_m_valid <= n_m_valid;
        end
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_step     <= n_step;
        r_walk_i   <= n_walk_i;
        r_walk_len <= n_walk_len;
        r_m_data   <= n_m_data;
        r_m_kind   <= n_m_kind;
        r_m_last   <= n_m_last;
    end

    // pending line memory
    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            line_mem[r_len] <= i_cmd.ch;
        end
        if (w_line_re) begin
            r_line_q <= line_mem[r_walk_i];
        end
    end

    // committed byte ring memory
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            ring_mem[r_wr_idx] <= w_push_byte;
        end
        if (w_ring_re) begin
            r_ring_q <= ring_mem[r_rd_idx];
        end
    end

endmodule

// File: sv/terminal_line_editor_top.sv
// top level of the canonical-mode terminal line editor
//
// channel   dir  handshake                      payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata rx_byte, tuser req_type
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata out_byte, tuser result_kind,
//                                                 tlast last
// cfg       in   i_cfg_valid/o_cfg_ready          data echo_enable
//
// an edit beat passes through the queue to the back part, which then sends its echo
// results if echo is enabled; a read answers from the ring; a line commit walks
// the line memory via its single read port, one ring push a cycle, then pushes LF
// reset is synchronous and active low; no clearing pass, memories start undefined
// a stalled m_axis holds the back part only while a result waits; the two-entry
// queue keeps s_axis accepting until it is full
`timescale 1ns / 1ps

module terminal_line_editor_top #(
    parameter int LINE_SIZE = 256,
    parameter int RING_SIZE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] req_type
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] result_kind
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_data        // [0] echo_enable
);
    import tle_pkg::*;

    logic  w_fq_valid;
    logic  w_fq_ready;
    t_cmd  w_fq_cmd;
    logic  w_qb_valid;
    logic  w_qb_ready;
    t_cmd  w_qb_cmd;
    t_kind w_kind;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tuser = w_kind;

    // classify incoming beats
    tle_front u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser[0]),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_cmd    (w_fq_cmd)
    );

    // decoupling queue
    tle_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_cmd   (w_fq_cmd),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_cmd    (w_qb_cmd)
    );

    // execute commands
    tle_back #(
        .LINE_SIZE (LINE_SIZE),
        .RING_SIZE (RING_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qb_valid),
        .o_cmd_ready (w_qb_ready),
        .i_cmd       (w_qb_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data[0]),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_kind    (w_kind),
        .o_m_last    (o_m_axis_tlast)
    );

endmodule

// File: sv/tle_checker.sv
// port-level checks on the line editor output stream, bound to the top level
`timescale 1ns / 1ps

module tle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import tle_pkg::*;

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid &&
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // only the three defined result kinds appear
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == KIND_ECHO || o_m_axis_tuser == KIND_DATA ||
        o_m_axis_tuser == KIND_EMPTY))
        else $error("undefined result kind");

    // an empty-ring report carries a zero byte
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_EMPTY |-> o_m_axis_tdata == 8'd0)
        else $error("empty report with nonzero byte");

    // a read answer is always the single and final beat of its request
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_ECHO |-> o_m_axis_tlast)
        else $error("read result without last");

endmodule

bind terminal_line_editor_top tle_checker u_tle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
